>>> rtl/ppmdec_pkg.sv
// ============================================================================
// ppmdec_pkg
// shared types, codes and constants of the ppm p6 stream decoder
// ============================================================================
package ppmdec_pkg;

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_WIDTH,
      PH_HEIGHT,
      PH_MAXVAL,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_MAGIC  = 3'd1,
      ST_DIMS   = 3'd2,
      ST_MAXVAL = 3'd3,
      ST_TRUNC  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [7:0] MAXVAL_ONLY  = 8'd255;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      status_type  status;
      logic        is_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type res_a;
      rsp_item_type res_b;
   } push_type;

   localparam rsp_item_type ITEM_NONE = '{
      kind: KIND_HEADER, image_width: 16'd0, image_height: 16'd0,
      red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0,
      status: ST_OK, is_last: 1'b0
   };

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
             (b == CH_CR) || (b == CH_FF);
   endfunction

   function automatic rsp_item_type status_item(input status_type st);
      rsp_item_type it;
      it         = ITEM_NONE;
      it.kind    = KIND_STATUS;
      it.status  = st;
      it.is_last = 1'b1;
      return it;
   endfunction

endpackage

>>> rtl/ppmdec_core.sv
// ============================================================================
// ppmdec_core
// input byte register, header tokenizer and pixel assembly; produces up to
// two result items per byte for the result queue
// ============================================================================
module ppmdec_core import ppmdec_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_byte,
   input  logic       req_eof,
   input  logic       room,
   output push_type   push
);

   localparam int AccW  = (DIM_BITS > 8) ? DIM_BITS : 8;
   localparam int CalcW = AccW + 4;
   localparam int PixW  = 2 * DIM_BITS;
   localparam int WideW = DIM_BITS + 16;
   localparam logic [CalcW-1:0] DimMax      = CalcW'((65'd1 << DIM_BITS) - 65'd1);
   localparam logic [CalcW-1:0] MaxvalLimit = CalcW'(MAXVAL_ONLY);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                in_eof_ff, in_eof_in;
   phase_type           phase_ff, phase_in;
   logic                comment_ff, comment_in;
   logic [1:0]          tok_len_ff, tok_len_in;
   logic [AccW-1:0]     acc_ff, acc_in;
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [PixW-1:0]     pix_left_ff, pix_left_in;
   logic [1:0]          chan_ff, chan_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;

   logic                take;
   logic [CalcW-1:0]    acc_calc;
   logic [CalcW-1:0]    lim;
   status_type          num_err;
   logic                is_digit;
   logic [WideW-1:0]    width_wide;
   logic [WideW-1:0]    height_wide;
   rsp_item_type        res_v [2];
   logic [1:0]          n;

   assign take       = in_valid_ff & room;
   assign req_tready = ~in_valid_ff | room;

   assign acc_calc    = CalcW'({acc_ff, 3'b000}) + CalcW'({acc_ff, 1'b0}) +
                        CalcW'(in_byte_ff[3:0]);
   assign is_digit    = (in_byte_ff >= CH_ZERO) && (in_byte_ff <= CH_NINE);
   assign lim         = (phase_ff == PH_MAXVAL) ? MaxvalLimit : DimMax;
   assign num_err     = (phase_ff == PH_MAXVAL) ? ST_MAXVAL : ST_DIMS;
   assign width_wide  = WideW'(width_ff);
   assign height_wide = WideW'(height_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eof_in   = in_eof_ff;
      phase_in    = phase_ff;
      comment_in  = comment_ff;
      tok_len_in  = tok_len_ff;
      acc_in      = acc_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      pix_left_in = pix_left_ff;
      chan_in     = chan_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      res_v[0]    = ITEM_NONE;
      res_v[1]    = ITEM_NONE;
      n           = 2'd0;

      if (take) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte;
         in_eof_in   = req_eof;
      end

      if (take) begin
         case (phase_ff)
            PH_DONE: begin
            end
            PH_PIXELS: begin
               case (chan_ff)
                  2'd0: begin
                     red_in  = in_byte_ff;
                     chan_in = 2'd1;
                  end
                  2'd1: begin
                     green_in = in_byte_ff;
                     chan_in  = 2'd2;
                  end
                  default: begin
                     res_v[n[0]]       = ITEM_NONE;
                     res_v[n[0]].kind  = KIND_PIXEL;
                     res_v[n[0]].red   = red_ff;
                     res_v[n[0]].green = green_ff;
                     res_v[n[0]].blue  = in_byte_ff;
                     res_v[n[0]].alpha = ALPHA_OPAQUE;
                     n                 = n + 2'd1;
                     chan_in           = 2'd0;
                     pix_left_in       = pix_left_ff - PixW'(1);
                     if (pix_left_ff == PixW'(1)) begin
                        res_v[n[0]] = status_item(ST_OK);
                        n           = n + 2'd1;
                        phase_in    = PH_DONE;
                     end
                  end
               endcase
            end
            default: begin
               if (comment_ff) begin
                  if (in_byte_ff == CH_LF) begin
                     comment_in = 1'b0;
                  end
               end else if (tok_len_ff == 2'd0 && is_space(in_byte_ff)) begin
               end else if (tok_len_ff == 2'd0 && in_byte_ff == CH_HASH) begin
                  comment_in = 1'b1;
               end else if (is_space(in_byte_ff)) begin
                  case (phase_ff)
                     PH_MAGIC: begin
                        if (tok_len_ff == 2'd2) begin
                           phase_in   = PH_WIDTH;
                           tok_len_in = 2'd0;
                           acc_in     = '0;
                        end else begin
                           res_v[n[0]] = status_item(ST_MAGIC);
                           n           = n + 2'd1;
                           phase_in    = PH_DONE;
                        end
                     end
                     PH_WIDTH: begin
                        width_in   = acc_ff[DIM_BITS-1:0];
                        phase_in   = PH_HEIGHT;
                        tok_len_in = 2'd0;
                        acc_in     = '0;
                     end
                     PH_HEIGHT: begin
                        height_in  = acc_ff[DIM_BITS-1:0];
                        phase_in   = PH_MAXVAL;
                        tok_len_in = 2'd0;
                        acc_in     = '0;
                     end
                     default: begin
                        if (acc_ff == AccW'(MAXVAL_ONLY)) begin
                           res_v[n[0]]              = ITEM_NONE;
                           res_v[n[0]].kind         = KIND_HEADER;
                           res_v[n[0]].image_width  = width_wide[15:0];
                           res_v[n[0]].image_height = height_wide[15:0];
                           n                        = n + 2'd1;
                           pix_left_in = PixW'(width_ff) * PixW'(height_ff);
                           chan_in     = 2'd0;
                           tok_len_in  = 2'd0;
                           phase_in    = PH_PIXELS;
                           if (width_ff == '0 || height_ff == '0) begin
                              res_v[n[0]] = status_item(ST_OK);
                              n           = n + 2'd1;
                              phase_in    = PH_DONE;
                           end
                        end else begin
                           res_v[n[0]] = status_item(ST_MAXVAL);
                           n           = n + 2'd1;
                           phase_in    = PH_DONE;
                        end
                     end
                  endcase
               end else if (phase_ff == PH_MAGIC) begin
                  if ((tok_len_ff == 2'd0 && in_byte_ff == CH_P) ||
                      (tok_len_ff == 2'd1 && in_byte_ff == CH_SIX)) begin
                     tok_len_in = tok_len_ff + 2'd1;
                  end else begin
                     res_v[n[0]] = status_item(ST_MAGIC);
                     n           = n + 2'd1;
                     phase_in    = PH_DONE;
                  end
               end else if (!is_digit) begin
                  res_v[n[0]] = status_item(num_err);
                  n           = n + 2'd1;
                  phase_in    = PH_DONE;
               end else begin
                  acc_in     = acc_calc[AccW-1:0];
                  tok_len_in = 2'd1;
                  if (acc_calc > lim) begin
                     res_v[n[0]] = status_item(num_err);
                     n           = n + 2'd1;
                     phase_in    = PH_DONE;
                  end
               end
            end
         endcase

         if (in_eof_ff) begin
            case (phase_in)
               PH_PIXELS: begin
                  res_v[n[0]] = status_item(ST_TRUNC);
                  n           = n + 2'd1;
               end
               PH_MAGIC: begin
                  res_v[n[0]] = status_item((tok_len_in == 2'd2) ? ST_DIMS : ST_MAGIC);
                  n           = n + 2'd1;
               end
               PH_WIDTH: begin
                  res_v[n[0]] = status_item(ST_DIMS);
                  n           = n + 2'd1;
               end
               PH_HEIGHT: begin
                  res_v[n[0]] = status_item((tok_len_in != 2'd0) ? ST_MAXVAL : ST_DIMS);
                  n           = n + 2'd1;
               end
               PH_MAXVAL: begin
                  res_v[n[0]] = status_item(
                     (tok_len_in != 2'd0 && acc_in == AccW'(MAXVAL_ONLY)) ?
                     ST_TRUNC : ST_MAXVAL);
                  n           = n + 2'd1;
               end
               default: begin
               end
            endcase
            phase_in    = PH_MAGIC;
            comment_in  = 1'b0;
            tok_len_in  = 2'd0;
            acc_in      = '0;
            width_in    = '0;
            height_in   = '0;
            pix_left_in = '0;
            chan_in     = 2'd0;
            red_in      = 8'd0;
            green_in    = 8'd0;
         end
      end
   end

   assign push.count = n;
   assign push.res_a = res_v[0];
   assign push.res_b = res_v[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_MAGIC;
         comment_ff  <= 1'b0;
         tok_len_ff  <= 2'd0;
         acc_ff      <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         pix_left_ff <= '0;
         chan_ff     <= 2'd0;
         red_ff      <= 8'd0;
         green_ff    <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         comment_ff  <= comment_in;
         tok_len_ff  <= tok_len_in;
         acc_ff      <= acc_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         pix_left_ff <= pix_left_in;
         chan_ff     <= chan_in;
         red_ff      <= red_in;
         green_ff    <= green_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eof_ff  <= in_eof_in;
   end

endmodule

>>> rtl/ppmdec_rsp_queue.sv
// ============================================================================
// ppmdec_rsp_queue
// four-entry result queue; takes up to two items per cycle, hands out one
// ============================================================================
module ppmdec_rsp_queue import ppmdec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop_ready,
   output logic         out_valid,
   output rsp_item_type out_item,
   output logic         room
);

   rsp_item_type           q_ff [QUEUE_DEPTH];
   rsp_item_type           q_in [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_next;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = q_ff[rd_ptr_ff];
   assign room      = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign pop       = out_valid & pop_ready;
   assign wr_next   = wr_ptr_ff + QUEUE_PTR_W'(1);

   always_comb begin
      q_in = q_ff;
      if (push.count != 2'd0) begin
         q_in[wr_ptr_ff] = push.res_a;
      end
      if (push.count == 2'd2) begin
         q_in[wr_next] = push.res_b;
      end
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

>>> rtl/ppm_p6_stream_decoder_unit.sv
// ============================================================================
// ppm_p6_stream_decoder_unit
// binary ppm (p6) byte stream decoder: header result, rgba pixels, status
// ============================================================================
// path: an accepted byte is held in the input byte register, decoded once the
//   result queue has room, and its results are written into the queue that drives rsp
// throughput: one byte per cycle while the result queue has room, set by the decode stage; a
//   byte with two results takes two slots of the four-entry result queue
// reset: synchronous, clears the parser state and empties the queue
module ppm_p6_stream_decoder_unit import ppmdec_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // image_width, image_height, red, green, blue, alpha, status
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // is_last
);

   push_type     push;
   logic         q_room;
   rsp_item_type head;

   ppmdec_core #(
      .DIM_BITS (DIM_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_eof    (req_tlast),
      .room       (q_room),
      .push       (push)
   );

   ppmdec_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (head),
      .room      (q_room)
   );

   assign rsp_tdata = {5'b00000, head.status, head.alpha, head.blue, head.green,
                       head.red, head.image_height, head.image_width};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.is_last;

   a_pixel_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_PIXEL) |-> (rsp_tdata[63:56] == ALPHA_OPAQUE))
      else $error("pixel result without opaque alpha");

   a_last_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_STATUS)))
      else $error("is_last does not match status kind");

   a_full_has_data: assert property (@(posedge clock) disable iff (reset)
      !q_room |-> rsp_tvalid)
      else $error("queue without room shows no result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
